FILE: sv/vstack_pkg.sv
// ----------------------------------------------------------------------------
// vstack_pkg
// Shared types and constants for the value stack with search and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vstack_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic push;
        logic pop;
        logic set_empty;
        logic set_full;
        logic scan_clear;
        logic issue;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  mode;
        logic empty;
        logic full;
        logic issue_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: sv/value_stack_with_search_remove_unit.sv
// Bounded LIFO stack of signed 32-bit values with push, pop, search and
// remove-all-equal, one result per request. Entries live in a single
// write / single read memory of STACK_DEPTH words. Push and pop pass through
// the execute and done states; search and remove walk the held entries
// through the memory read port one per cycle, then a flush and a done state
// (straight to done on an empty stack), remove compacting survivors in
// place on the same walk. A finished result sits in an output register, so a
// new request is taken while the previous result is still stalled; a
// request finishing while that result is still held waits in its done state.
// entry_count shows the fill count in 7 bits.
// ----------------------------------------------------------------------------
// value_stack_with_search_remove_unit
// Top level: controller and datapath of the searchable value stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module value_stack_with_search_remove_unit
#(
    parameter int STACK_DEPTH = vstack_pkg::STACK_DEPTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [vstack_pkg::MODE_W-1:0]           mode,
    input  logic signed [vstack_pkg::DATA_W-1:0]    value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [vstack_pkg::DATA_W-1:0]    popped_value,
    output logic                                    found,
    output logic [vstack_pkg::STATUS_W-1:0]         status,
    output logic [vstack_pkg::COUNT_OUT_W-1:0]      entry_count
);

    vstack_pkg::ctrl_cmd_t cmd;
    vstack_pkg::dp_sts_t   sts;

    vstack_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vstack_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .value        (value),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count)
    );

endmodule

FILE: sv/vstack_ctrl.sv
// ----------------------------------------------------------------------------
// vstack_ctrl
// Sequencer for push, pop and the search / remove walk over the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vstack_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vstack_pkg::dp_sts_t    sts,
    output vstack_pkg::ctrl_cmd_t  cmd
);

    vstack_pkg::state_t state_reg;
    vstack_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vstack_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vstack_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vstack_pkg::S_EXEC;
                end
            end
            vstack_pkg::S_EXEC:
            begin
                if ((sts.mode == vstack_pkg::OP_SEARCH || sts.mode == vstack_pkg::OP_REMOVE)
                    && !sts.empty)
                begin
                    state_next = vstack_pkg::S_SCAN;
                end
                else
                begin
                    state_next = vstack_pkg::S_DONE;
                end
            end
            vstack_pkg::S_SCAN:
            begin
                if (sts.issue_last)
                begin
                    state_next = vstack_pkg::S_FLUSH;
                end
            end
            vstack_pkg::S_FLUSH:
            begin
                state_next = vstack_pkg::S_DONE;
            end
            vstack_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = vstack_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vstack_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            vstack_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            vstack_pkg::S_EXEC:
            begin
                unique case (sts.mode)
                    vstack_pkg::OP_PUSH:
                    begin
                        cmd.set_full = sts.full;
                        cmd.push     = !sts.full;
                    end
                    vstack_pkg::OP_POP:
                    begin
                        cmd.set_empty = sts.empty;
                        cmd.pop       = !sts.empty;
                    end
                    vstack_pkg::OP_SEARCH, vstack_pkg::OP_REMOVE:
                    begin
                        cmd.set_empty  = sts.empty;
                        cmd.scan_clear = !sts.empty;
                    end
                    default:
                    begin
                        cmd.set_empty = 1'b0;
                    end
                endcase
            end
            vstack_pkg::S_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            vstack_pkg::S_FLUSH:
            begin
                // last entry is compared this cycle; count takes the kept total
                cmd.commit = (sts.mode == vstack_pkg::OP_REMOVE);
            end
            vstack_pkg::S_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: sv/vstack_dp.sv
// ----------------------------------------------------------------------------
// vstack_dp
// Store, fill count, scan pointers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vstack_dp
#(
    parameter int STACK_DEPTH = vstack_pkg::STACK_DEPTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [vstack_pkg::MODE_W-1:0]           mode,
    input  logic signed [vstack_pkg::DATA_W-1:0]    value,
    input  vstack_pkg::ctrl_cmd_t                   cmd,
    output vstack_pkg::dp_sts_t                     sts,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [vstack_pkg::DATA_W-1:0]    popped_value,
    output logic                                    found,
    output logic [vstack_pkg::STATUS_W-1:0]         status,
    output logic [vstack_pkg::COUNT_OUT_W-1:0]      entry_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [vstack_pkg::DATA_W-1:0] mem [STACK_DEPTH];

    vstack_pkg::op_t               op_mode_reg,  op_mode_next;
    logic [vstack_pkg::DATA_W-1:0] op_value_reg, op_value_next;
    logic [CW-1:0]                 count_reg,    count_next;
    logic [AW-1:0]                 idx_reg,      idx_next;
    logic [CW-1:0]                 kept_reg,     kept_next;
    logic                          found_reg,    found_next;
    vstack_pkg::status_t           res_status_reg, res_status_next;
    logic                          rd_vld_reg;
    logic [vstack_pkg::DATA_W-1:0] rd_data_reg;

    logic                                   out_valid_reg, out_valid_next;
    logic [vstack_pkg::DATA_W-1:0]          out_popped_reg;
    logic                                   out_found_reg;
    logic [vstack_pkg::STATUS_W-1:0]        out_status_reg;
    logic [vstack_pkg::COUNT_OUT_W-1:0]     out_count_reg;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [vstack_pkg::DATA_W-1:0] wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          out_free;
    logic                          pop_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop_ok   = (op_mode_reg == vstack_pkg::OP_POP)
                      && (res_status_reg == vstack_pkg::ST_OK);

    always_comb
    begin
        sts.mode       = op_mode_reg;
        sts.empty      = (count_reg == '0);
        sts.full       = (count_reg == CW'(STACK_DEPTH));
        sts.issue_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.out_free   = out_free;
    end

    always_comb
    begin
        op_mode_next    = op_mode_reg;
        op_value_next   = op_value_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        kept_next       = kept_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        if (cmd.capture)
        begin
            op_mode_next    = vstack_pkg::op_t'(mode);
            op_value_next   = value;
            found_next      = 1'b0;
            res_status_next = vstack_pkg::ST_OK;
        end
        if (cmd.set_empty)
        begin
            res_status_next = vstack_pkg::ST_EMPTY;
        end
        if (cmd.set_full)
        begin
            res_status_next = vstack_pkg::ST_FULL;
        end
        if (cmd.push)
        begin
            wr_en      = 1'b1;
            wr_addr    = count_reg[AW-1:0];
            wr_data    = op_value_reg;
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            rd_en      = 1'b1;
            rd_addr    = count_next[AW-1:0];
        end
        if (cmd.scan_clear)
        begin
            idx_next  = '0;
            kept_next = '0;
        end
        if (cmd.issue)
        begin
            rd_en    = 1'b1;
            rd_addr  = idx_reg;
            idx_next = idx_reg + AW'(1);
        end
        // compare the entry read last cycle; survivors slide down to kept
        if (rd_vld_reg)
        begin
            if (rd_data_reg == op_value_reg)
            begin
                found_next = 1'b1;
            end
            else if (op_mode_reg == vstack_pkg::OP_REMOVE)
            begin
                wr_en     = 1'b1;
                wr_addr   = kept_reg[AW-1:0];
                wr_data   = rd_data_reg;
                kept_next = kept_reg + CW'(1);
            end
        end
        if (cmd.commit)
        begin
            count_next = kept_next;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg    <= op_mode_next;
        op_value_reg   <= op_value_next;
        idx_reg        <= idx_next;
        kept_reg       <= kept_next;
        if (cmd.load_out)
        begin
            out_popped_reg <= pop_ok ? rd_data_reg : '0;
            out_found_reg  <= found_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= vstack_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            found_reg      <= 1'b0;
            res_status_reg <= vstack_pkg::ST_OK;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            found_reg      <= found_next;
            res_status_reg <= res_status_next;
            rd_vld_reg     <= cmd.issue;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign entry_count  = out_count_reg;

endmodule
